// File: rtl/core/chm_pkg.sv
// Shared types and constants of the chained hash map unit.
// No dependencies; every other file in rtl/core except chm_ram imports this package.
package chm_pkg;

    localparam int MAX_BUCKETS   = 1024;
    localparam int POOL_NODES    = 1024;
    localparam int KEY_W         = 63;
    localparam int VAL_W         = 32;
    localparam int BCNT_W        = 11;
    localparam int BCNT_RESET    = 1024;
    localparam int BKT_W         = $clog2(MAX_BUCKETS);
    localparam int NODE_W        = $clog2(POOL_NODES);
    localparam int LINK_W        = NODE_W + 1;
    localparam int FREE_W        = $clog2(POOL_NODES + 1);
    localparam int DIGIT_W       = 8;
    localparam int KEY_STEPS     = (KEY_W + DIGIT_W - 1) / DIGIT_W;
    localparam int SH_W          = KEY_STEPS * DIGIT_W;
    localparam int STEP_W        = (KEY_STEPS > 1) ? $clog2(KEY_STEPS) : 1;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    typedef logic [1:0] cmd_t;

    localparam cmd_t CMD_LOOKUP = 2'd0;
    localparam cmd_t CMD_INSERT = 2'd1;
    localparam cmd_t CMD_ERASE  = 2'd2;

    typedef struct packed {
        cmd_t                     command;
        logic [KEY_W-1:0]         key;
        logic signed [VAL_W-1:0]  value;
        logic signed [VAL_W-1:0]  miss_value;
        logic [BKT_W-1:0]         bucket;
    } job_t;

    typedef struct packed {
        logic              clearing;
        logic [FREE_W-1:0] free_count;
    } back_stat_t;

endpackage

// File: rtl/core/chm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module chm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/chm_front.sv
// Front end: accepts requests and reduces the key to its bucket, one byte per cycle.
// Depends on chm_pkg.
module chm_front
    import chm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_stall,
    input  cmd_t                    command,
    input  logic [KEY_W-1:0]        key,
    input  logic signed [VAL_W-1:0] value,
    input  logic signed [VAL_W-1:0] miss_value,
    input  logic [BCNT_W-1:0]       bucket_count,
    input  logic                    clearing,
    input  logic                    q_full,
    output logic                    q_push,
    output job_t                    q_entry
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [BCNT_W-1:0]   rem_reg, rem_next;
    logic [SH_W-1:0]     sh_reg, sh_next;
    job_t                job_reg, job_next;
    logic [BCNT_W-1:0]   divisor;
    logic [BCNT_W-1:0]   r;

    always_comb
    begin
        priority if (bucket_count == '0)
        begin
            divisor = BCNT_W'(1);
        end
        else if (bucket_count > BCNT_W'(MAX_BUCKETS))
        begin
            divisor = BCNT_W'(MAX_BUCKETS);
        end
        else
        begin
            divisor = bucket_count;
        end
    end

    // one digit of restoring division: shift in a key bit, subtract if it fits
    always_comb
    begin
        r = rem_reg;
        for (int i = 0; i < DIGIT_W; i++)
        begin
            r = {r[BCNT_W-2:0], sh_reg[SH_W-1-i]};
            if (r >= divisor)
            begin
                r = r - divisor;
            end
        end
    end

    assign req_stall = busy_reg | clearing;
    assign q_push    = busy_reg & done_reg & ~q_full;

    always_comb
    begin
        q_entry        = job_reg;
        q_entry.bucket = rem_reg[BKT_W-1:0];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        job_next  = job_reg;
        if (!busy_reg)
        begin
            if (req_valid && !req_stall)
            begin
                busy_next           = 1'b1;
                done_next           = 1'b0;
                step_next           = '0;
                rem_next            = '0;
                sh_next             = SH_W'(key);
                job_next.command    = command;
                job_next.key        = key;
                job_next.value      = value;
                job_next.miss_value = miss_value;
                job_next.bucket     = '0;
            end
        end
        else if (!done_reg)
        begin
            rem_next  = r;
            sh_next   = sh_reg << DIGIT_W;
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(KEY_STEPS - 1))
            begin
                done_next = 1'b1;
            end
        end
        else if (q_push)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        job_reg <= job_next;
    end

endmodule

// File: rtl/core/chm_queue.sv
// Short FIFO of classified requests between the front and back ends.
// Depends on chm_pkg.
module chm_queue
    import chm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_entry,
    input  logic pop,
    output job_t head,
    output logic empty,
    output logic full
);

    job_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_reg, wr_next;
    logic [QPTR_W-1:0]  rd_reg, rd_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign head  = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_next = (rd_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_entry;
        end
    end

endmodule

// File: rtl/core/chm_back.sv
// Back end: walks bucket chains in the table memories and applies lookup, insert, erase.
// Depends on chm_pkg and chm_ram.
module chm_back
    import chm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_empty,
    input  job_t                    q_head,
    output logic                    q_pop,
    output logic                    res_valid,
    input  logic                    res_stall,
    output logic signed [VAL_W-1:0] read_value,
    output logic                    hit,
    output logic                    pool_full,
    output back_stat_t              stat
);

    localparam logic [3:0] ST_CLR   = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_HWAIT = 4'd2;
    localparam logic [3:0] ST_NODE  = 4'd3;
    localparam logic [3:0] ST_ACT   = 4'd4;
    localparam logic [3:0] ST_ALLOC = 4'd5;
    localparam logic [3:0] ST_LINK  = 4'd6;
    localparam logic [3:0] ST_DONE  = 4'd7;

    logic [3:0]              state_reg, state_next;
    logic [BKT_W-1:0]        clr_reg, clr_next;
    logic [FREE_W-1:0]       free_cnt_reg, free_cnt_next;
    logic [FREE_W-1:0]       min_cnt_reg, min_cnt_next;
    logic                    has_prev_reg, has_prev_next;
    logic                    found_reg, found_next;
    logic                    full_reg, full_next;
    logic                    res_valid_reg, res_valid_next;
    job_t                    job_reg, job_next;
    logic [NODE_W-1:0]       cur_reg, cur_next;
    logic [NODE_W-1:0]       prev_reg, prev_next;
    logic [NODE_W-1:0]       new_node_reg, new_node_next;
    logic [NODE_W-1:0]       fresh_idx_reg, fresh_idx_next;
    logic                    fresh_reg, fresh_next;
    logic signed [VAL_W-1:0] val_cap_reg, val_cap_next;
    logic [LINK_W-1:0]       link_cap_reg, link_cap_next;
    logic signed [VAL_W-1:0] rv_reg, rv_next;
    logic                    hit_reg, hit_next;
    logic                    pf_reg, pf_next;
    logic [FREE_W-1:0]       cnt_dec;
    logic [NODE_W-1:0]       alloc_n;

    logic                    head_we;
    logic [BKT_W-1:0]        head_waddr, head_raddr;
    logic [LINK_W-1:0]       head_wdata, head_rdata;
    logic                    key_we, val_we, link_we, stack_we;
    logic [NODE_W-1:0]       key_waddr, val_waddr, link_waddr, node_raddr;
    logic [KEY_W-1:0]        key_wdata, key_rdata;
    logic [VAL_W-1:0]        val_wdata, val_rdata;
    logic [LINK_W-1:0]       link_wdata, link_rdata;
    logic [NODE_W-1:0]       stack_waddr, stack_raddr, stack_wdata, stack_rdata;

    chm_ram #(.WIDTH(LINK_W), .DEPTH(MAX_BUCKETS)) u_heads (
        .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .raddr(head_raddr), .rdata(head_rdata)
    );
    chm_ram #(.WIDTH(KEY_W), .DEPTH(POOL_NODES)) u_keys (
        .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
        .raddr(node_raddr), .rdata(key_rdata)
    );
    chm_ram #(.WIDTH(VAL_W), .DEPTH(POOL_NODES)) u_vals (
        .clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
        .raddr(node_raddr), .rdata(val_rdata)
    );
    chm_ram #(.WIDTH(LINK_W), .DEPTH(POOL_NODES)) u_links (
        .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
        .raddr(node_raddr), .rdata(link_rdata)
    );
    chm_ram #(.WIDTH(NODE_W), .DEPTH(POOL_NODES)) u_stack (
        .clk(clk), .we(stack_we), .waddr(stack_waddr), .wdata(stack_wdata),
        .raddr(stack_raddr), .rdata(stack_rdata)
    );

    assign res_valid       = res_valid_reg;
    assign read_value      = rv_reg;
    assign hit             = hit_reg;
    assign pool_full       = pf_reg;
    assign stat.clearing   = (state_reg == ST_CLR);
    assign stat.free_count = free_cnt_reg;
    assign cnt_dec         = free_cnt_reg - FREE_W'(1);
    assign alloc_n         = fresh_reg ? fresh_idx_reg : stack_rdata;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        free_cnt_next  = free_cnt_reg;
        min_cnt_next   = min_cnt_reg;
        has_prev_next  = has_prev_reg;
        found_next     = found_reg;
        full_next      = full_reg;
        res_valid_next = res_valid_reg & res_stall;
        job_next       = job_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        new_node_next  = new_node_reg;
        fresh_idx_next = fresh_idx_reg;
        fresh_next     = fresh_reg;
        val_cap_next   = val_cap_reg;
        link_cap_next  = link_cap_reg;
        rv_next        = rv_reg;
        hit_next       = hit_reg;
        pf_next        = pf_reg;
        q_pop          = 1'b0;
        head_we        = 1'b0;
        head_waddr     = job_reg.bucket;
        head_wdata     = link_cap_reg;
        head_raddr     = job_reg.bucket;
        key_we         = 1'b0;
        key_waddr      = alloc_n;
        key_wdata      = job_reg.key;
        val_we         = 1'b0;
        val_waddr      = cur_reg;
        val_wdata      = job_reg.value;
        link_we        = 1'b0;
        link_waddr     = prev_reg;
        link_wdata     = link_cap_reg;
        node_raddr     = cur_reg;
        stack_we       = 1'b0;
        stack_waddr    = free_cnt_reg[NODE_W-1:0];
        stack_wdata    = cur_reg;
        stack_raddr    = cnt_dec[NODE_W-1:0];

        unique case (state_reg)
            ST_CLR:
            begin
                head_we    = 1'b1;
                head_waddr = clr_reg;
                head_wdata = '0;
                clr_next   = clr_reg + BKT_W'(1);
                if (clr_reg == BKT_W'(MAX_BUCKETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop         = 1'b1;
                    job_next      = q_head;
                    head_raddr    = q_head.bucket;
                    has_prev_next = 1'b0;
                    found_next    = 1'b0;
                    full_next     = 1'b0;
                    if (q_head.command == CMD_LOOKUP || q_head.command == CMD_INSERT ||
                        q_head.command == CMD_ERASE)
                    begin
                        state_next = ST_HWAIT;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_HWAIT:
            begin
                if (head_rdata[NODE_W])
                begin
                    node_raddr = head_rdata[NODE_W-1:0];
                    cur_next   = head_rdata[NODE_W-1:0];
                    state_next = ST_NODE;
                end
                else
                begin
                    state_next = ST_ACT;
                end
            end
            ST_NODE:
            begin
                // one node per cycle: compare, else follow the link
                if (key_rdata == job_reg.key)
                begin
                    found_next    = 1'b1;
                    val_cap_next  = val_rdata;
                    link_cap_next = link_rdata;
                    state_next    = ST_ACT;
                end
                else
                begin
                    prev_next     = cur_reg;
                    has_prev_next = 1'b1;
                    if (link_rdata[NODE_W])
                    begin
                        cur_next   = link_rdata[NODE_W-1:0];
                        node_raddr = link_rdata[NODE_W-1:0];
                    end
                    else
                    begin
                        state_next = ST_ACT;
                    end
                end
            end
            ST_ACT:
            begin
                state_next = ST_DONE;
                unique case (job_reg.command)
                    CMD_INSERT:
                    begin
                        if (found_reg)
                        begin
                            val_we = 1'b1;
                        end
                        else if (free_cnt_reg == '0)
                        begin
                            full_next = 1'b1;
                        end
                        else
                        begin
                            // stack slots below the low-water mark were never written
                            free_cnt_next  = cnt_dec;
                            fresh_next     = (cnt_dec < min_cnt_reg);
                            fresh_idx_next = NODE_W'(POOL_NODES - 1) - cnt_dec[NODE_W-1:0];
                            if (cnt_dec < min_cnt_reg)
                            begin
                                min_cnt_next = cnt_dec;
                            end
                            state_next = ST_ALLOC;
                        end
                    end
                    CMD_ERASE:
                    begin
                        if (found_reg)
                        begin
                            if (has_prev_reg)
                            begin
                                link_we = 1'b1;
                            end
                            else
                            begin
                                head_we = 1'b1;
                            end
                            if (free_cnt_reg < FREE_W'(POOL_NODES))
                            begin
                                stack_we      = 1'b1;
                                free_cnt_next = free_cnt_reg + FREE_W'(1);
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_ALLOC:
            begin
                key_we        = 1'b1;
                val_we        = 1'b1;
                val_waddr     = alloc_n;
                link_we       = 1'b1;
                link_waddr    = alloc_n;
                link_wdata    = '0;
                new_node_next = alloc_n;
                if (has_prev_reg)
                begin
                    state_next = ST_LINK;
                end
                else
                begin
                    head_we    = 1'b1;
                    head_wdata = {1'b1, alloc_n};
                    state_next = ST_DONE;
                end
            end
            ST_LINK:
            begin
                link_we    = 1'b1;
                link_wdata = {1'b1, new_node_reg};
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next = 1'b1;
                    hit_next       = found_reg;
                    pf_next        = full_reg;
                    if (job_reg.command == CMD_LOOKUP)
                    begin
                        rv_next = found_reg ? val_cap_reg : job_reg.miss_value;
                    end
                    else
                    begin
                        rv_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            clr_reg       <= '0;
            free_cnt_reg  <= FREE_W'(POOL_NODES);
            min_cnt_reg   <= FREE_W'(POOL_NODES);
            has_prev_reg  <= 1'b0;
            found_reg     <= 1'b0;
            full_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            free_cnt_reg  <= free_cnt_next;
            min_cnt_reg   <= min_cnt_next;
            has_prev_reg  <= has_prev_next;
            found_reg     <= found_next;
            full_reg      <= full_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg       <= job_next;
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        new_node_reg  <= new_node_next;
        fresh_idx_reg <= fresh_idx_next;
        fresh_reg     <= fresh_next;
        val_cap_reg   <= val_cap_next;
        link_cap_reg  <= link_cap_next;
        rv_reg        <= rv_next;
        hit_reg       <= hit_next;
        pf_reg        <= pf_next;
    end

endmodule

// File: rtl/core/chained_hash_map_unit.sv
// Top level of the chained hash map unit: front end, request queue and back end.
// Depends on chm_pkg, chm_front, chm_queue, chm_back (and chm_ram below it).
//
// Key-to-value map with separate chaining over a 1024-node pool. Each request
// (lookup, insert/update, erase) yields exactly one result. After reset the
// unit clears all MAX_BUCKETS (1024) entries of the bucket-head memory, with
// req_stall high. The front end reduces the key modulo bucket_count one byte
// per cycle: it holds req_stall through each request (accept, 8 modulo
// steps, hand-off), and the hand-off waits while the two-entry queue is full.
// The back end then walks the chain one node per cycle through the node
// memories (registered read). A lookup or an erase passes through HWAIT,
// NODE for each chain node visited, ACT and DONE; an unknown command goes
// from IDLE straight to DONE, and an insert of a new key adds ALLOC, plus
// LINK when it appends to a chain. The result then waits in its register
// until taken. The front end overlaps the next request's modulo with that
// walk. bucket_count is written through cfg_*, which is always ready;
// write it only while no request is in flight. A bucket_count of 0 acts
// as 1 and values above 1024 act as 1024.
module chained_hash_map_unit
    import chm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_stall,
    input  cmd_t                    command,
    input  logic [KEY_W-1:0]        key,
    input  logic signed [VAL_W-1:0] value,
    input  logic signed [VAL_W-1:0] miss_value,
    output logic                    res_valid,
    input  logic                    res_stall,
    output logic signed [VAL_W-1:0] read_value,
    output logic                    hit,
    output logic                    pool_full,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [BCNT_W-1:0]       cfg_data
);

    logic [BCNT_W-1:0] bucket_count_reg, bucket_count_next;
    logic              q_push, q_pop, q_empty, q_full;
    job_t              q_in, q_head;
    back_stat_t        stat;

    // config register: accept every write
    assign cfg_ready = 1'b1;

    always_comb
    begin
        bucket_count_next = bucket_count_reg;
        if (cfg_valid && cfg_ready)
        begin
            bucket_count_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_count_reg <= BCNT_W'(BCNT_RESET);
        end
        else
        begin
            bucket_count_reg <= bucket_count_next;
        end
    end

    // front end: take a request, compute its bucket
    chm_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .command      (command),
        .key          (key),
        .value        (value),
        .miss_value   (miss_value),
        .bucket_count (bucket_count_reg),
        .clearing     (stat.clearing),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_entry      (q_in)
    );

    // decouple the two ends
    chm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty),
        .full       (q_full)
    );

    // back end: walk the chain, update the tables, drive the result register
    chm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .read_value (read_value),
        .hit        (hit),
        .pool_full  (pool_full),
        .stat       (stat)
    );

    // never push into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("request queue overflow");

    // free count stays within the pool
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.free_count <= FREE_W'(POOL_NODES))
        else $error("free count beyond pool size");

    // no result and no queued request while the head memory is being cleared
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        stat.clearing |-> (!res_valid && q_empty))
        else $error("activity during head clearing");

    // a pool-full flag only ever comes with a miss
    a_full_miss: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(pool_full && hit))
        else $error("pool_full together with hit");

endmodule
